// ===== rtl/lifo_stack_with_reverse_top_assert.svh =====
// assertion macros for the lifo stack block
`ifndef LIFO_STACK_WITH_REVERSE_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_REVERSE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lifo stack assertion failed");

// next-cycle implication, checked out of reset
`define LSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lifo stack assertion failed");

`endif

// ===== rtl/lsr_pkg.sv =====
// types, codes and defaults shared by the lifo stack block
`default_nettype none
package lsr_pkg;

  // default stack depth
  localparam int LSR_DEPTH = 64;

  // action codes
  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_PEEK    = 3'd1;
  localparam logic [2:0] ACT_POP     = 3'd2;
  localparam logic [2:0] ACT_DISPLAY = 3'd3;
  localparam logic [2:0] ACT_REVERSE = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // request payload
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } lsr_in_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] data_value;
    logic [1:0]         status;
    logic               last_of_run;
  } lsr_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_DISP_RD,
    S_DISP_EM,
    S_REV_CHK,
    S_REV_RDHI,
    S_REV_WRLO,
    S_REV_WRHI
  } lsr_state_t;

endpackage
`default_nettype wire

// ===== rtl/lifo_stack_with_reverse_top.sv =====
// lifo stack of signed words with peek, pop, display and in-place reverse
// Usage:
//   in_valid/in_ready carry one request (action, push_value); out_valid/out_ready
//   carry results (data_value, status, last_of_run). A request is taken only
//   in the idle state; a result waiting in the output register does not block
//   acceptance.
//   All actions go through one memory with registered read data and one
//   sequencer:
//     push, or any empty/full report: result set in the pending register
//     peek, pop: top word read, then result set in the pending register (S_TOP)
//     display: S_DISP_RD then S_DISP_EM per stored word, one result per word
//     reverse: S_REV_CHK, S_REV_RDHI, S_REV_WRLO, S_REV_WRHI per swapped pair
//     action codes 5 to 7: no result, no change
//   Each request that gives a result gives its last result with last_of_run set.
//   Reset (rst_n low, synchronous) empties the stack and drops any pending
//   result; the stored words themselves are not cleared.
//   When the receiver stalls, the result holds in the output register and the
//   sequencer waits before producing the next one; nothing is lost.
`default_nettype none
module lifo_stack_with_reverse_top #(
  parameter int DEPTH = lsr_pkg::LSR_DEPTH
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  lsr_pkg::lsr_in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output lsr_pkg::lsr_out_t out_data
);
  import lsr_pkg::*;

  `include "lifo_stack_with_reverse_top_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // word store
  logic signed [31:0] mem [DEPTH];

  lsr_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [AW-1:0]      hi_r, hi_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;
  logic signed [31:0] rd_data_r;
  lsr_out_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  lsr_out_t           pend_r, pend_nxt;
  logic               pend_valid_r, pend_valid_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               rd_en;
  logic [AW-1:0]      raddr;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               disp_last;
  logic [AW-1:0]      top_addr;
  logic [CW-1:0]      count_m1;
  logic               push_go;
  logic               disp_done_go;
  logic               disp_done_ok;
  logic               rev_busy;

  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_m1  = count_r - CW'(1);
  assign top_addr  = count_m1[AW-1:0];
  assign disp_last = ((CW'(lo_r) + CW'(1)) == count_r);

  assign in_ready  = (state_r == S_IDLE) && !pend_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    tmp_r  <= tmp_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    tmp_nxt        = tmp_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    we             = 1'b0;
    waddr          = count_r[AW-1:0];
    wdata          = in_data.push_value;
    rd_en          = 1'b0;
    raddr          = top_addr;

    // single-result hand-off to the output register
    if (pend_valid_r && out_free) begin
      out_nxt        = pend_r;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.action)
            ACT_PUSH: begin
              pend_valid_nxt = 1'b1;
              if (full) begin
                pend_nxt = '{data_value: '0, status: STAT_FULL, last_of_run: 1'b1};
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CW'(1);
                pend_nxt  = '{data_value: '0, status: STAT_OK, last_of_run: 1'b1};
              end
            end
            ACT_PEEK, ACT_POP: begin
              if (empty) begin
                pend_valid_nxt = 1'b1;
                pend_nxt = '{data_value: '0, status: STAT_EMPTY, last_of_run: 1'b1};
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_TOP;
                if (in_data.action == ACT_POP) begin
                  count_nxt = count_m1;
                end
              end
            end
            ACT_DISPLAY: begin
              if (empty) begin
                pend_valid_nxt = 1'b1;
                pend_nxt = '{data_value: '0, status: STAT_EMPTY, last_of_run: 1'b1};
              end else begin
                lo_nxt    = '0;
                state_nxt = S_DISP_RD;
              end
            end
            ACT_REVERSE: begin
              if (empty) begin
                pend_valid_nxt = 1'b1;
                pend_nxt = '{data_value: '0, status: STAT_EMPTY, last_of_run: 1'b1};
              end else begin
                lo_nxt    = '0;
                hi_nxt    = top_addr;
                state_nxt = S_REV_CHK;
              end
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end
      // top word arrives from the memory
      S_TOP: begin
        pend_valid_nxt = 1'b1;
        pend_nxt  = '{data_value: rd_data_r, status: STAT_OK, last_of_run: 1'b1};
        state_nxt = S_IDLE;
      end
      // display walks bottom to top
      S_DISP_RD: begin
        rd_en     = 1'b1;
        raddr     = lo_r;
        state_nxt = S_DISP_EM;
      end
      S_DISP_EM: begin
        if (out_free && !pend_valid_r) begin
          out_nxt       = '{data_value: rd_data_r, status: STAT_OK, last_of_run: disp_last};
          out_valid_nxt = 1'b1;
          if (disp_last) begin
            state_nxt = S_IDLE;
          end else begin
            lo_nxt    = lo_r + AW'(1);
            state_nxt = S_DISP_RD;
          end
        end
      end
      // reverse swaps from both ends inward
      S_REV_CHK: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          raddr     = lo_r;
          state_nxt = S_REV_RDHI;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_nxt  = '{data_value: '0, status: STAT_OK, last_of_run: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_REV_RDHI: begin
        tmp_nxt   = rd_data_r;
        rd_en     = 1'b1;
        raddr     = hi_r;
        state_nxt = S_REV_WRLO;
      end
      S_REV_WRLO: begin
        we        = 1'b1;
        waddr     = lo_r;
        wdata     = rd_data_r;
        state_nxt = S_REV_WRHI;
      end
      S_REV_WRHI: begin
        we        = 1'b1;
        waddr     = hi_r;
        wdata     = tmp_r;
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = S_REV_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // conditions watched by the checks
  assign push_go      = in_valid && in_ready && (in_data.action == ACT_PUSH) && !full;
  assign disp_done_go = (state_r == S_DISP_EM) && out_free && !pend_valid_r && disp_last;
  assign disp_done_ok = (state_r == S_IDLE) && out_valid_r && out_r.last_of_run;
  assign rev_busy     = (state_r == S_REV_RDHI) || (state_r == S_REV_WRLO) ||
                        (state_r == S_REV_WRHI);

  // checks
  `LSR_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `LSR_ASSERT_NEXT(a_push_count, push_go, count_r == $past(count_r) + CW'(1))
  `LSR_ASSERT_NEXT(a_disp_done, disp_done_go, disp_done_ok)
  `LSR_ASSERT_IMPL(a_rev_no_out, rev_busy, !pend_valid_r && !in_ready)

endmodule
`default_nettype wire

// ===== verif/lifo_stack_with_reverse_checker.sv =====
// checker for the lifo stack: predicts results from accepted requests and compares
`timescale 1ns / 100ps
module lifo_stack_with_reverse_checker #(
  parameter int DEPTH = lsr_pkg::LSR_DEPTH
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  lsr_pkg::lsr_in_t  in_data,
  input  wire               out_valid,
  input  wire               out_ready,
  input  lsr_pkg::lsr_out_t out_data,
  output int                fail_count,
  output int                pending_count
);
  import lsr_pkg::*;

  // keep the log short when things go badly wrong
  localparam int PRINT_CAP = 60;

  // predicted stack contents
  logic signed [31:0] word_stack [DEPTH];
  int                 stack_fill;

  // results still owed by the block, oldest first
  lsr_out_t owed_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    stack_fill    = 0;
  end

  // one line per mismatch up to PRINT_CAP, always counted
  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic lsr_out_t make_result(input logic signed [31:0] data,
                                           input logic [1:0] status,
                                           input logic last);
    lsr_out_t res;
    res.data_value  = data;
    res.status      = status;
    res.last_of_run = last;
    return res;
  endfunction

  // work out what one accepted request must produce
  task automatic predict_results(input lsr_in_t req);
    int lo;
    int hi;
    logic signed [31:0] swap;
    case (req.action)
      ACT_PUSH: begin
        if (stack_fill >= DEPTH) begin
          owed_results.push_back(make_result('0, STAT_FULL, 1'b1));
        end else begin
          word_stack[stack_fill] = req.push_value;
          stack_fill++;
          owed_results.push_back(make_result('0, STAT_OK, 1'b1));
        end
      end
      ACT_PEEK, ACT_POP: begin
        if (stack_fill == 0) begin
          owed_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
        end else begin
          owed_results.push_back(make_result(word_stack[stack_fill - 1], STAT_OK, 1'b1));
          if (req.action == ACT_POP) stack_fill--;
        end
      end
      ACT_DISPLAY: begin
        if (stack_fill == 0) begin
          owed_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < stack_fill; i++) begin
            owed_results.push_back(make_result(word_stack[i], STAT_OK,
                                               (i == stack_fill - 1)));
          end
        end
      end
      ACT_REVERSE: begin
        if (stack_fill == 0) begin
          owed_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
        end else begin
          lo = 0;
          hi = stack_fill - 1;
          while (lo < hi) begin
            swap           = word_stack[lo];
            word_stack[lo] = word_stack[hi];
            word_stack[hi] = swap;
            lo++;
            hi--;
          end
          owed_results.push_back(make_result('0, STAT_OK, 1'b1));
        end
      end
      default: begin
        // unused codes: no result, no change
      end
    endcase
  endtask

  // compare one result against the oldest owed one, field by field
  task automatic check_result(input lsr_out_t got);
    lsr_out_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result data %0d status %0d last %0b",
                                got.data_value, got.status, got.last_of_run));
    end else begin
      want = owed_results.pop_front();
      if (got.data_value !== want.data_value)
        report_mismatch($sformatf("data_value got %0d want %0d",
                                  got.data_value, want.data_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run got %0b want %0b",
                                  got.last_of_run, want.last_of_run));
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      stack_fill = 0;
    end else begin
      if (in_valid && in_ready) predict_results(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    pending_count <= owed_results.size();
  end

endmodule

// ===== verif/lifo_stack_with_reverse_top_tb.sv =====
// testbench top for the lifo stack: stimulus, receiver pacing and verdict
`timescale 1ns / 100ps
module lifo_stack_with_reverse_top_tb;
  import lsr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lsr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lsr_out_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;
  int cycle_count;
  int fail_count;
  int pending_count;

  lifo_stack_with_reverse_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lifo_stack_with_reverse_checker stack_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lifo_stack_with_reverse_top regression: fail");
    $finish;
  end

  // receiver pacing, with a long hold-off on demand
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input logic [2:0] act, input logic signed [31:0] val);
    lsr_in_t req;
    req.action     = act;
    req.push_value = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // random mix; ignored codes do not count
  task automatic send_random(input int count, input int push_pct);
    int         sent;
    int         roll;
    logic [2:0] act;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        act = ACT_PUSH;
      end else begin
        roll = $urandom_range(99);
        if (roll < 40) act = ACT_POP;
        else if (roll < 55) act = ACT_PEEK;
        else if (roll < 70) act = ACT_DISPLAY;
        else if (roll < 92) act = ACT_REVERSE;
        else act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      end
      send_request(act, pick_value());
      if (act <= ACT_REVERSE) sent++;
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    hold_request  = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 70;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reports, single word, even and odd reverse, ignored codes
    send_request(ACT_POP, 32'sd5);
    send_request(ACT_PEEK, 32'sd6);
    send_request(ACT_DISPLAY, 32'sd7);
    send_request(ACT_REVERSE, 32'sd8);
    send_request(ACT_PUSH, WORD_MAX);
    send_request(ACT_REVERSE, '0);
    send_request(ACT_PEEK, '0);
    send_request(ACT_PUSH, WORD_MIN);
    send_request(ACT_PUSH, '0);
    send_request(ACT_PUSH, -32'sd1);
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_REVERSE, '0);
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_REVERSE, '0);
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_PEEK, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_POP, '0);
    send_request(ACT_UNUSED_FIRST, WORD_MAX);
    send_request(ACT_UNUSED_MID, WORD_MIN);
    send_request(ACT_UNUSED_LAST, -32'sd1);
    send_request(ACT_PUSH, 32'sh5a5a_a5a5);

    // slow receiver
    send_random(6, 55);

    // slow sender
    send_idle_pct = 70;
    recv_idle_pct = 17;
    send_random(6, 45);

    // full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(6, 40);

    // pause until drained, then fill to full, starting behind a stalled receiver
    wait_drained();
    hold_request = 1'b1;
    repeat (65) send_request(ACT_PUSH, pick_value());
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_REVERSE, '0);
    send_request(ACT_DISPLAY, '0);
    send_request(ACT_PEEK, '0);

    // end of run
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("lifo_stack_with_reverse_top regression: pass");
    end else begin
      $display("lifo_stack_with_reverse_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lsr_pkg.sv
rtl/lifo_stack_with_reverse_top.sv
verif/lifo_stack_with_reverse_checker.sv
verif/lifo_stack_with_reverse_top_tb.sv
